/* hw/rtl/tdor_pkg.sv */
package tdor_pkg;

  localparam int NUM_DIMS   = 3;
  localparam int COORD_BITS = 8;
  localparam int MAX_VCS    = 16;

  localparam int DIM_W     = $clog2(NUM_DIMS + 1);
  localparam int COORDS_W  = NUM_DIMS * COORD_BITS;
  localparam int VC_W      = $clog2(MAX_VCS);
  localparam int VCNT_W    = VC_W + 1;
  localparam int PORT_W    = 7;
  localparam int TERM_W    = 6;
  localparam int CONC_W    = 7;
  localparam int NVC_CFG_W = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int DIST_W    = COORD_BITS + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONCENTRATION = 3'd0,
    CFG_NUM_VCS       = 3'd1,
    CFG_INPUT_PORT    = 3'd2,
    CFG_DIM_WIDTHS    = 3'd3,
    CFG_ROUTER_COORDS = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [COORDS_W-1:0] dest_coords;
    logic [TERM_W-1:0]   dest_terminal;
    logic [3:0]          current_vc;
    logic                tie_break;
  } in_item_t;

  typedef struct packed {
    logic [PORT_W-1:0] out_port;
    logic [VC_W-1:0]   out_vc;
    logic              last_vc;
  } out_item_t;

  typedef struct packed {
    logic [CONC_W-1:0]    concentration;
    logic [NVC_CFG_W-1:0] num_vcs;
    logic [PORT_W-1:0]    input_port;
    logic [COORDS_W-1:0]  dim_widths;
    logic [COORDS_W-1:0]  router_coords;
  } cfg_t;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [VCNT_W-1:0] first_vc;
    logic              step_two;
    logic [VCNT_W-1:0] vc_limit;
  } route_t;

  function automatic logic [1:0] ports_of(input logic [COORD_BITS-1:0] w);
    return (w == COORD_BITS'(2)) ? 2'd1 : 2'd2;
  endfunction

endpackage

/* hw/rtl/torus_dim_order_route.sv */
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   in_item_t: dest_coords, dest_terminal,
//                                          current_vc, tie_break
// out_      output     out_valid/out_stall out_item_t: out_port, out_vc, last_vc
// cfg_      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A head flit spends three pipeline stages on route computation; the VC sequencer
// then registers one result per allowed VC, one per cycle unless the output stalls.
// A flit that yields no result emits nothing; the route stages take a new flit
// every cycle unless a stall backs up into them.
// Reset is synchronous, clears the valid bits and loads the configuration defaults.
// A stall on the output backs up through the stages without losing or repeating a flit.
module torus_dim_order_route (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  tdor_pkg::in_item_t                  in_data,
  output logic                                in_stall,
  output logic                                out_valid,
  output tdor_pkg::out_item_t                 out_data,
  input  logic                                out_stall,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tdor_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tdor_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tdor_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  logic   route_valid, route_stall;
  route_t route;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CONCENTRATION: cfg_nxt.concentration = cfg_data[CONC_W-1:0];
        CFG_NUM_VCS:       cfg_nxt.num_vcs       = cfg_data[NVC_CFG_W-1:0];
        CFG_INPUT_PORT:    cfg_nxt.input_port    = cfg_data[PORT_W-1:0];
        CFG_DIM_WIDTHS:    cfg_nxt.dim_widths    = cfg_data[COORDS_W-1:0];
        CFG_ROUTER_COORDS: cfg_nxt.router_coords = cfg_data[COORDS_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.concentration <= CONC_W'(1);
      cfg_r.num_vcs       <= NVC_CFG_W'(2);
      cfg_r.input_port    <= '0;
      cfg_r.dim_widths    <= COORDS_W'(24'h020202);
      cfg_r.router_coords <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_ready = 1'b1;

  tdor_route_pipe u_route_pipe (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .in_stall    (in_stall),
    .route_valid (route_valid),
    .route       (route),
    .route_stall (route_stall)
  );

  tdor_vc_emit u_vc_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .route_valid (route_valid),
    .route       (route),
    .route_stall (route_stall),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .out_stall   (out_stall)
  );

endmodule

/* hw/rtl/tdor_route_pipe.sv */
module tdor_route_pipe (
  input  logic              clk,
  input  logic              rst_n,
  input  tdor_pkg::cfg_t    cfg,
  input  logic              in_valid,
  input  tdor_pkg::in_item_t in_data,
  output logic              in_stall,
  output logic              route_valid,
  output tdor_pkg::route_t  route,
  input  logic              route_stall
);
  import tdor_pkg::*;

  logic en1, en2, en3;

  // Stage 1: first differing dimension, port base and input dimension.
  logic                  v1_r, v1_nxt;
  logic                  at_dest_r;
  logic                  same_dim_r;
  logic [PORT_W-1:0]     base1_r;
  logic [COORD_BITS-1:0] src1_r, dst1_r, w1_r;
  logic [TERM_W-1:0]     term1_r;
  logic                  cls_in1_r, tie1_r;

  logic                  s1_found;
  logic [DIM_W-1:0]      s1_dim;
  logic [PORT_W:0]       s1_base;
  logic [COORD_BITS-1:0] s1_src, s1_dst, s1_w;
  logic                  s1_in_net, s1_in_hit;
  logic [DIM_W-1:0]      s1_in_dim;
  logic [PORT_W:0]       s1_off, s1_lim;

  always_comb begin
    s1_found = 1'b0;
    s1_dim   = DIM_W'(NUM_DIMS);
    s1_base  = {1'b0, cfg.concentration};
    s1_src   = '0;
    s1_dst   = '0;
    s1_w     = '0;
    for (int d = 0; d < NUM_DIMS; d++) begin
      if (!s1_found) begin
        if (cfg.router_coords[d*COORD_BITS +: COORD_BITS] !=
            in_data.dest_coords[d*COORD_BITS +: COORD_BITS]) begin
          s1_found = 1'b1;
          s1_dim   = DIM_W'(d);
          s1_src   = cfg.router_coords[d*COORD_BITS +: COORD_BITS];
          s1_dst   = in_data.dest_coords[d*COORD_BITS +: COORD_BITS];
          s1_w     = cfg.dim_widths[d*COORD_BITS +: COORD_BITS];
        end else begin
          s1_base = s1_base +
                    (PORT_W+1)'(ports_of(cfg.dim_widths[d*COORD_BITS +: COORD_BITS]));
        end
      end
    end
  end

  always_comb begin
    s1_in_net = (cfg.input_port >= cfg.concentration);
    s1_off    = {1'b0, cfg.input_port} - {1'b0, cfg.concentration};
    s1_lim    = '0;
    s1_in_hit = 1'b0;
    s1_in_dim = '0;
    for (int d = 0; d < NUM_DIMS; d++) begin
      s1_lim = s1_lim + (PORT_W+1)'(ports_of(cfg.dim_widths[d*COORD_BITS +: COORD_BITS]));
      if (!s1_in_hit && s1_in_net && (s1_off < s1_lim)) begin
        s1_in_hit = 1'b1;
        s1_in_dim = DIM_W'(d);
      end
    end
  end

  assign v1_nxt = en1 ? in_valid : v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      at_dest_r  <= !s1_found;
      same_dim_r <= s1_found && s1_in_hit && (s1_in_dim == s1_dim);
      base1_r    <= s1_base[PORT_W-1:0];
      src1_r     <= s1_src;
      dst1_r     <= s1_dst;
      w1_r       <= s1_w;
      term1_r    <= in_data.dest_terminal;
      cls_in1_r  <= in_data.current_vc[0];
      tie1_r     <= in_data.tie_break;
    end
  end

  // Stage 2: ring distances and VC class.
  logic              v2_r, v2_nxt;
  logic              at_dest2_r, w_two_r, dist_eq_r, plus_lt_r, cls2_r, tie2_r;
  logic [PORT_W-1:0] base2_r;
  logic [TERM_W-1:0] term2_r;

  logic signed [DIST_W-1:0] s2_src, s2_dst, s2_w, s2_plus, s2_minus;
  logic                     s2_wrap_hop, s2_cls;
  logic [COORD_BITS-1:0]    s2_wm1;

  always_comb begin
    s2_src   = $signed({2'b00, src1_r});
    s2_dst   = $signed({2'b00, dst1_r});
    s2_w     = $signed({2'b00, w1_r});
    s2_plus  = (dst1_r > src1_r) ? (s2_dst - s2_src) : (s2_dst + s2_w - s2_src);
    s2_minus = (src1_r > dst1_r) ? (s2_src - s2_dst) : (s2_src + s2_w - s2_dst);
    s2_wm1   = w1_r - COORD_BITS'(1);
    s2_wrap_hop = (w1_r != '0) &&
                  (((src1_r == '0) && (dst1_r == s2_wm1)) ||
                   ((dst1_r == '0) && (src1_r == s2_wm1)));
    s2_cls = same_dim_r ? (s2_wrap_hop ? 1'b1 : cls_in1_r) : 1'b0;
  end

  assign v2_nxt = en2 ? v1_r : v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      at_dest2_r <= at_dest_r;
      w_two_r    <= (w1_r == COORD_BITS'(2));
      dist_eq_r  <= (s2_plus == s2_minus);
      plus_lt_r  <= (s2_plus < s2_minus);
      cls2_r     <= s2_cls;
      tie2_r     <= tie1_r;
      base2_r    <= base1_r;
      term2_r    <= term1_r;
    end
  end

  // Stage 3: port selection and VC range.
  logic   v3_r, v3_nxt;
  route_t route_r, s3_route;
  logic   s3_step_up;

  always_comb begin
    if (w_two_r) begin
      s3_step_up = 1'b0;
    end else if (dist_eq_r) begin
      s3_step_up = tie2_r;
    end else begin
      s3_step_up = !plus_lt_r;
    end
    if (at_dest2_r) begin
      s3_route.port     = PORT_W'(term2_r);
      s3_route.first_vc = '0;
      s3_route.step_two = 1'b0;
    end else begin
      s3_route.port     = base2_r + PORT_W'(s3_step_up);
      s3_route.first_vc = VCNT_W'(cls2_r);
      s3_route.step_two = 1'b1;
    end
    if (cfg.num_vcs > NVC_CFG_W'(MAX_VCS)) begin
      s3_route.vc_limit = VCNT_W'(MAX_VCS);
    end else begin
      s3_route.vc_limit = VCNT_W'(cfg.num_vcs);
    end
  end

  assign v3_nxt = en3 ? v2_r : v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      route_r <= s3_route;
    end
  end

  assign en3 = !v3_r || !route_stall;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_stall    = !en1;
  assign route_valid = v3_r;
  assign route       = route_r;

endmodule

/* hw/rtl/tdor_vc_emit.sv */
module tdor_vc_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                route_valid,
  input  tdor_pkg::route_t    route,
  output logic                route_stall,
  output logic                out_valid,
  output tdor_pkg::out_item_t out_data,
  input  logic                out_stall
);
  import tdor_pkg::*;

  logic              busy_r, busy_nxt;
  logic [PORT_W-1:0] port_r, port_nxt;
  logic [VCNT_W-1:0] vc_r, vc_nxt;
  logic              step_two_r, step_two_nxt;
  logic [VCNT_W-1:0] limit_r, limit_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              slot_free, is_last, load_ok, load;
  logic [VCNT_W-1:0] vc_next;

  always_comb begin
    slot_free = !out_valid_r || !out_stall;
    vc_next   = vc_r + (step_two_r ? VCNT_W'(2) : VCNT_W'(1));
    is_last   = (vc_next >= limit_r);
    load_ok   = !busy_r || (slot_free && is_last);
    load      = route_valid && load_ok;
  end

  always_comb begin
    busy_nxt      = busy_r;
    port_nxt      = port_r;
    vc_nxt        = vc_r;
    step_two_nxt  = step_two_r;
    limit_nxt     = limit_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (slot_free) begin
      out_valid_nxt = busy_r;
      if (busy_r) begin
        out_data_nxt.out_port = port_r;
        out_data_nxt.out_vc   = vc_r[VC_W-1:0];
        out_data_nxt.last_vc  = is_last;
        vc_nxt                = vc_next;
        busy_nxt              = !is_last;
      end
    end
    if (load) begin
      busy_nxt     = (route.first_vc < route.vc_limit);
      port_nxt     = route.port;
      vc_nxt       = route.first_vc;
      step_two_nxt = route.step_two;
      limit_nxt    = route.vc_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    port_r     <= port_nxt;
    vc_r       <= vc_nxt;
    step_two_r <= step_two_nxt;
    limit_r    <= limit_nxt;
    out_data_r <= out_data_nxt;
  end

  assign route_stall = !load_ok;
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;

endmodule

/* hw/rtl/tdor_checker.sv */
module tdor_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            out_valid,
  input  tdor_pkg::out_item_t             out_data,
  input  logic                            out_stall,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready
);
  import tdor_pkg::*;

  // An offered flit that is stalled stays offered.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid)
    else $error("stalled input withdrawn");

  // A result that is held back keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Reset empties the output register.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The results of one flit follow each other without gaps on the same port
  // with rising VC numbers.
  a_flit_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_vc |=>
      out_valid && (out_data.out_port == $past(out_data.out_port)) &&
      (out_data.out_vc > $past(out_data.out_vc)))
    else $error("flit results broken up");

  // Configuration transfers are never refused.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind torus_dim_order_route tdor_checker u_tdor_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_data  (out_data),
  .out_stall (out_stall),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

/* tb/torus_dim_order_route_checker.sv */
module torus_dim_order_route_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  tdor_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  tdor_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [tdor_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tdor_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              errors,
  output int                              outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import tdor_pkg::*;

  cfg_t      route_cfg;
  out_item_t vc_grants_q[$];
  out_item_t want;
  int        mismatch_cnt = 0;

  function automatic int coord_of(logic [COORDS_W-1:0] vec, int d);
    return int'(vec[d*COORD_BITS +: COORD_BITS]);
  endfunction

  function automatic int ring_ports(int w);
    return (w == 2) ? 1 : 2;
  endfunction

  function automatic void add_grant(int port, int vc, bit last);
    out_item_t g;
    g.out_port = PORT_W'(port);
    g.out_vc   = VC_W'(vc);
    g.last_vc  = last;
    vc_grants_q.push_back(g);
  endfunction

  // Dimension-order route with dateline classes; pushes one grant per allowed VC.
  function automatic void route_flit(in_item_t f);
    int nvc, base, in_dim, off, d, dim, src, dst, w, fwd, bwd, port, cls, vc;
    nvc = (route_cfg.num_vcs > MAX_VCS) ? MAX_VCS : int'(route_cfg.num_vcs);
    base = int'(route_cfg.concentration);
    in_dim = -1;
    if (route_cfg.input_port >= route_cfg.concentration) begin
      off = int'(route_cfg.input_port) - int'(route_cfg.concentration);
      for (d = 0; d < NUM_DIMS && in_dim < 0; d++) begin
        if (off < ring_ports(coord_of(route_cfg.dim_widths, d))) in_dim = d;
        else off -= ring_ports(coord_of(route_cfg.dim_widths, d));
      end
    end
    dim = NUM_DIMS;
    for (d = 0; d < NUM_DIMS; d++) begin
      if (dim == NUM_DIMS) begin
        if (coord_of(route_cfg.router_coords, d) != coord_of(f.dest_coords, d)) dim = d;
        else base += ring_ports(coord_of(route_cfg.dim_widths, d));
      end
    end
    if (dim == NUM_DIMS) begin
      for (vc = 0; vc < nvc; vc++) add_grant(int'(f.dest_terminal), vc, vc == nvc - 1);
    end else begin
      src = coord_of(route_cfg.router_coords, dim);
      dst = coord_of(f.dest_coords, dim);
      w   = coord_of(route_cfg.dim_widths, dim);
      if (w == 2) begin
        port = base;
      end else begin
        fwd = (dst > src) ? dst - src : dst + w - src;
        bwd = (src > dst) ? src - dst : src + w - dst;
        if (fwd == bwd) port = base + int'(f.tie_break);
        else if (fwd < bwd) port = base;
        else port = base + 1;
      end
      if (dim != in_dim) cls = 0;
      else if ((src == 0 && dst == w - 1) || (dst == 0 && src == w - 1)) cls = 1;
      else cls = int'(f.current_vc[0]);
      for (vc = cls; vc < nvc; vc += 2) add_grant(port, vc, vc + 2 >= nvc);
    end
  endfunction

  function automatic void report(string field, int exp_v, int got_v);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, got_v);
    mismatch_cnt++;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      route_cfg.concentration = CONC_W'(1);
      route_cfg.num_vcs       = NVC_CFG_W'(2);
      route_cfg.input_port    = '0;
      route_cfg.dim_widths    = COORDS_W'(24'h020202);
      route_cfg.router_coords = '0;
      vc_grants_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CONCENTRATION: route_cfg.concentration = cfg_data[CONC_W-1:0];
          CFG_NUM_VCS:       route_cfg.num_vcs       = cfg_data[NVC_CFG_W-1:0];
          CFG_INPUT_PORT:    route_cfg.input_port    = cfg_data[PORT_W-1:0];
          CFG_DIM_WIDTHS:    route_cfg.dim_widths    = cfg_data[COORDS_W-1:0];
          CFG_ROUTER_COORDS: route_cfg.router_coords = cfg_data[COORDS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) route_flit(in_data);
      if (out_valid && !out_stall) begin
        if (vc_grants_q.size() == 0) begin
          $display("%0t: transfer with nothing expected, actual port %0d vc %0d last %0b",
                   $time, out_data.out_port, out_data.out_vc, out_data.last_vc);
          mismatch_cnt++;
        end else begin
          want = vc_grants_q.pop_front();
          if (out_data.out_port !== want.out_port)
            report("out_port", int'(want.out_port), int'(out_data.out_port));
          if (out_data.out_vc !== want.out_vc)
            report("out_vc", int'(want.out_vc), int'(out_data.out_vc));
          if (out_data.last_vc !== want.last_vc)
            report("last_vc", int'(want.last_vc), int'(out_data.last_vc));
        end
      end
    end
    errors <= mismatch_cnt;
    outstanding <= vc_grants_q.size();
  end

endmodule

/* tb/torus_dim_order_route_tb.sv */
module torus_dim_order_route_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tdor_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASES         = 14;
  localparam int PHASE_FLITS    = 24;
  localparam int PRESSURE_PHASE = 3;
  localparam int PRESSURE_FLITS = 40;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  in_item_t              in_data;
  logic                  in_stall;
  logic                  out_valid;
  out_item_t             out_data;
  logic                  out_stall;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int               errors;
  int               outstanding;
  int               quiet_cycles = 0;
  bit               in_gaps_on = 1'b0;
  bit               out_stalls_on = 1'b0;
  bit               hold_req = 1'b0;
  logic [COORDS_W-1:0] cur_widths = COORDS_W'(24'h020202);
  logic [COORDS_W-1:0] cur_coords = '0;

  always #5ns clk = ~clk;

  torus_dim_order_route dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  torus_dim_order_route_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The receiver holds off for a long stretch in the pressure phase so the block backs up.
  initial begin
    int n;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (out_stalls_on) begin
        n = $urandom_range(0, 14);
        if (n > 0) out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic drain();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(int conc, int nvc, int iport, logic [COORDS_W-1:0] widths,
                           logic [COORDS_W-1:0] coords);
    in_valid <= 1'b0;
    drain();
    write_reg(CFG_CONCENTRATION, {17'($urandom), 7'(conc)});
    write_reg(CFG_NUM_VCS, {19'($urandom), 5'(nvc)});
    write_reg(CFG_INPUT_PORT, {17'($urandom), 7'(iport)});
    write_reg(CFG_DIM_WIDTHS, widths);
    write_reg(CFG_ROUTER_COORDS, coords);
    cfg_valid <= 1'b0;
    cur_widths = widths;
    cur_coords = coords;
  endtask

  task automatic send_flit(in_item_t f);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic in_item_t flit(logic [COORDS_W-1:0] dest, int term, int vc, bit tie);
    in_item_t f;
    f.dest_coords   = dest;
    f.dest_terminal = TERM_W'(term);
    f.current_vc    = 4'(vc);
    f.tie_break     = tie;
    return f;
  endfunction

  function automatic in_item_t random_flit();
    in_item_t f;
    int d, wd;
    f = flit(cur_coords, $urandom_range(0, 63), $urandom_range(0, 15), 1'($urandom));
    case ($urandom_range(0, 9))
      0: ;
      1: f.dest_coords = COORDS_W'($urandom);
      default: begin
        for (d = 0; d < NUM_DIMS; d++) begin
          if ($urandom_range(0, 1) == 1) begin
            wd = int'(cur_widths[d*COORD_BITS +: COORD_BITS]);
            if (wd < 2) f.dest_coords[d*COORD_BITS +: COORD_BITS] = COORD_BITS'($urandom);
            else begin
              case ($urandom_range(0, 3))
                0: f.dest_coords[d*COORD_BITS +: COORD_BITS] = '0;
                1: f.dest_coords[d*COORD_BITS +: COORD_BITS] = COORD_BITS'(wd - 1);
                default: f.dest_coords[d*COORD_BITS +: COORD_BITS] =
                  COORD_BITS'($urandom_range(0, wd - 1));
              endcase
            end
          end
        end
      end
    endcase
    return f;
  endfunction

  task automatic random_setup();
    logic [COORDS_W-1:0] w, c;
    int d, wd, conc, nvc, iport;
    bit wild;
    wild = ($urandom_range(0, 4) == 0);
    for (d = 0; d < NUM_DIMS; d++) begin
      case ($urandom_range(0, 3))
        0: wd = 2;
        1: wd = $urandom_range(3, 6);
        2: wd = $urandom_range(2, 255);
        default: wd = wild ? $urandom_range(0, 255) : $urandom_range(7, 12);
      endcase
      w[d*COORD_BITS +: COORD_BITS] = COORD_BITS'(wd);
      c[d*COORD_BITS +: COORD_BITS] = (wild || wd < 1) ? COORD_BITS'($urandom)
                                                       : COORD_BITS'($urandom_range(0, wd - 1));
    end
    conc  = wild ? $urandom_range(0, 127) : $urandom_range(1, 64);
    nvc   = wild ? $urandom_range(0, 31) : $urandom_range(2, 16);
    iport = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                        : (conc + $urandom_range(0, 6)) % 128;
    configure(conc, nvc, iport, w, c);
  endtask

  task automatic run_directed();
    configure(4, 4, 4, 24'h080205, 24'h030100);
    send_flit(flit(24'h030100, 63, 15, 1'b1));
    send_flit(flit(24'h030100, 0, 0, 1'b0));
    send_flit(flit(24'h030104, 5, 0, 1'b0));
    send_flit(flit(24'h030101, 5, 1, 1'b0));
    send_flit(flit(24'h030102, 5, 0, 1'b1));
    send_flit(flit(24'h030103, 5, 1, 1'b0));
    send_flit(flit(24'h0301C8, 5, 1, 1'b1));
    send_flit(flit(24'h030000, 7, 1, 1'b0));
    send_flit(flit(24'h070100, 7, 3, 1'b0));
    send_flit(flit(24'h070100, 7, 3, 1'b1));
    send_flit(flit(24'hFFFFFF, 63, 15, 1'b1));
    send_flit(flit(24'h000000, 0, 0, 1'b0));
    configure(127, 31, 127, 24'hFFFFFF, 24'hFFFFFF);
    send_flit(flit(24'hFFFF00, 42, 1, 1'b0));
    send_flit(flit(24'hFFFFFE, 21, 0, 1'b1));
    send_flit(flit(24'hFFFFFF, 63, 15, 1'b1));
    send_flit(flit(24'h00FFFF, 0, 14, 1'b0));
    configure(0, 0, 0, 24'h000100, 24'h000000);
    send_flit(flit(24'h000000, 9, 2, 1'b0));
    send_flit(flit(24'h000001, 9, 3, 1'b1));
    configure(1, 1, 1, 24'h020202, 24'h000001);
    send_flit(flit(24'h000000, 3, 0, 1'b0));
    send_flit(flit(24'h010001, 3, 1, 1'b1));
    send_flit(flit(24'h000001, 63, 0, 1'b0));
    configure(2, 6, 4, 24'h010100, 24'h000000);
    send_flit(flit(24'h000005, 1, 0, 1'b0));
    send_flit(flit(24'h000300, 1, 1, 1'b1));
    send_flit(flit(24'h000100, 1, 0, 1'b0));
  endtask

  initial begin
    int p, k, count;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_CONCENTRATION;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    for (p = 0; p < PHASES; p++) begin
      if (p == PRESSURE_PHASE) begin
        configure(4, 16, 5, 24'h040404, 24'h000000);
        in_gaps_on    = 1'b0;
        out_stalls_on = 1'b1;
        hold_req      = 1'b1;
        count         = PRESSURE_FLITS;
      end else begin
        random_setup();
        in_gaps_on    = ($urandom_range(0, 3) != 0);
        out_stalls_on = ($urandom_range(0, 3) != 0);
        count         = PHASE_FLITS;
      end
      for (k = 0; k < count; k++) send_flit(random_flit());
    end
    in_valid <= 1'b0;
    drain();
    if (errors == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/tdor_pkg.sv
hw/rtl/tdor_route_pipe.sv
hw/rtl/tdor_vc_emit.sv
hw/rtl/torus_dim_order_route.sv
hw/rtl/tdor_checker.sv
tb/torus_dim_order_route_checker.sv
tb/torus_dim_order_route_tb.sv
